@@ rtl/fti_pkg.sv @@
// fti_pkg: shared types, constants and helper functions of the escape-time iterator
// no dependencies; imported by fti_fixmul, fti_core and escape_time_fractal_iterator
package fti_pkg;

    // default parameter values
    localparam int DEF_COORD_WIDTH = 32;
    localparam int DEF_FRAC_BITS   = 28;
    localparam int DEF_COUNT_WIDTH = 16;

    // internal datapath: z components are 64-bit signed, clamped to +/-(2^63-1)
    localparam int Z_WIDTH    = 64;
    localparam int HALF_WIDTH = Z_WIDTH / 2;
    localparam int PROD_WIDTH = 2 * Z_WIDTH;
    localparam int MAG_WIDTH  = 52;

    localparam logic signed [Z_WIDTH-1:0] ZMAX    = {1'b0, {(Z_WIDTH-1){1'b1}}};
    localparam logic signed [Z_WIDTH-1:0] ZMIN    = {1'b1, {(Z_WIDTH-1){1'b0}}};
    localparam logic [MAG_WIDTH-1:0]      MAG_MAX = {MAG_WIDTH{1'b1}};

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_KIND     = 2'd0,
        CFG_MAX_ITER = 2'd1,
        CFG_C_REAL   = 2'd2,
        CFG_C_IMAG   = 2'd3
    } t_cfg_index;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_UPDATE,
        ST_DONE
    } t_core_state;

    // which product the shared multiplier works on
    typedef enum logic [1:0] {
        PROD_RR,
        PROD_II,
        PROD_RI
    } t_prod;

    // request to the shared multiplier
    typedef struct packed {
        logic start;
        logic half_shift;
    } t_mul_req;

    // saturate a widened sum to the clamp range
    function automatic logic signed [Z_WIDTH-1:0] sat_z(input logic signed [Z_WIDTH+1:0] v);
        logic signed [Z_WIDTH+1:0] lim_hi;
        logic signed [Z_WIDTH+1:0] lim_lo;
        lim_hi = (Z_WIDTH+2)'(ZMAX);
        lim_lo = -lim_hi;
        if (v > lim_hi) begin
            return ZMAX;
        end else if (v < lim_lo) begin
            return -ZMAX;
        end
        return v[Z_WIDTH-1:0];
    endfunction

    // the most negative 64-bit value is pulled into the symmetric range
    function automatic logic signed [Z_WIDTH-1:0] clamp_z(input logic signed [Z_WIDTH-1:0] v);
        return (v == ZMIN) ? -ZMAX : v;
    endfunction

    // round(0.8 * 2^frac), split so that no intermediate overflows
    function automatic logic [Z_WIDTH-1:0] c_real_default_mag(input int frac);
        logic [Z_WIDTH-1:0] one;
        one = Z_WIDTH'(1) << frac;
        return (one / 5) * 4 + ((one % 5) * 4 + 2) / 5;
    endfunction

    // round(0.156 * 2^frac)
    function automatic logic [Z_WIDTH-1:0] c_imag_default_mag(input int frac);
        logic [Z_WIDTH-1:0] one;
        one = Z_WIDTH'(1) << frac;
        return (one / 250) * 39 + ((one % 250) * 39 + 125) / 250;
    endfunction

endpackage

@@ rtl/fti_fixmul.sv @@
// fti_fixmul: shared fixed-point multiplier, floor(a*b / 2^s) saturated to +/-(2^63-1)
// four 32x32 partial products over successive cycles; depends on fti_pkg
module fti_fixmul
    import fti_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_mul_req                  i_req,
    input  logic signed [Z_WIDTH-1:0] i_a,
    input  logic signed [Z_WIDTH-1:0] i_b,
    output logic                      o_done,
    output logic signed [Z_WIDTH-1:0] o_result
);

    localparam int NUM_PP     = 4;
    localparam int STEP_DONE  = NUM_PP + 1;
    localparam int STEP_WIDTH = $clog2(STEP_DONE + 1);

    logic                    r_busy;
    logic [STEP_WIDTH-1:0]   r_step;
    logic [Z_WIDTH-1:0]      r_ma;
    logic [Z_WIDTH-1:0]      r_mb;
    logic                    r_neg;
    logic                    r_half;
    logic [Z_WIDTH-1:0]      r_pp;
    logic [1:0]              r_pp_pos;
    logic [PROD_WIDTH-1:0]   r_acc;

    logic [Z_WIDTH-1:0]      a_mag;
    logic [Z_WIDTH-1:0]      b_mag;
    logic [PROD_WIDTH-1:0]   bias;
    logic [HALF_WIDTH-1:0]   a_sel;
    logic [HALF_WIDTH-1:0]   b_sel;
    logic [Z_WIDTH-1:0]      pp_next;
    logic [1:0]              pp_pos_next;
    logic [PROD_WIDTH-1:0]   pp_shifted;
    logic [PROD_WIDTH-1:0]   quot;
    logic                    quot_sat;
    logic [Z_WIDTH-2:0]      mag_out;

    // operand magnitudes and floor bias for negative products
    assign a_mag = i_a[Z_WIDTH-1] ? Z_WIDTH'(-i_a) : i_a;
    assign b_mag = i_b[Z_WIDTH-1] ? Z_WIDTH'(-i_b) : i_b;
    assign bias  = (i_a[Z_WIDTH-1] ^ i_b[Z_WIDTH-1])
                 ? ((PROD_WIDTH'(1) << (i_req.half_shift ? FRAC_BITS - 1 : FRAC_BITS))
                    - PROD_WIDTH'(1))
                 : '0;

    // partial product select: step bit 1 picks a half, step bit 0 picks b half
    assign a_sel       = r_step[1] ? r_ma[Z_WIDTH-1:HALF_WIDTH] : r_ma[HALF_WIDTH-1:0];
    assign b_sel       = r_step[0] ? r_mb[Z_WIDTH-1:HALF_WIDTH] : r_mb[HALF_WIDTH-1:0];
    assign pp_next     = a_sel * b_sel;
    assign pp_pos_next = {1'b0, r_step[1]} + {1'b0, r_step[0]};

    // align the registered partial product
    always_comb begin
        case (r_pp_pos)
            2'd0:    pp_shifted = {{Z_WIDTH{1'b0}}, r_pp};
            2'd1:    pp_shifted = {{HALF_WIDTH{1'b0}}, r_pp, {HALF_WIDTH{1'b0}}};
            default: pp_shifted = {r_pp, {Z_WIDTH{1'b0}}};
        endcase
    end

    // sequencing control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            if (r_step == STEP_WIDTH'(STEP_DONE)) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + STEP_WIDTH'(1);
            end
        end
    end

    // operands, partial product and accumulator
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ma   <= a_mag;
            r_mb   <= b_mag;
            r_neg  <= i_a[Z_WIDTH-1] ^ i_b[Z_WIDTH-1];
            r_half <= i_req.half_shift;
            r_acc  <= bias;
        end else if (r_busy) begin
            if (r_step < STEP_WIDTH'(NUM_PP)) begin
                r_pp     <= pp_next;
                r_pp_pos <= pp_pos_next;
            end
            if (r_step != '0 && r_step <= STEP_WIDTH'(NUM_PP)) begin
                r_acc <= r_acc + pp_shifted;
            end
        end
    end

    // shift, saturate and restore the sign
    assign quot     = r_half ? (r_acc >> (FRAC_BITS - 1)) : (r_acc >> FRAC_BITS);
    assign quot_sat = |quot[PROD_WIDTH-1:Z_WIDTH-1];
    assign mag_out  = quot_sat ? ZMAX[Z_WIDTH-2:0] : quot[Z_WIDTH-2:0];
    assign o_result = r_neg ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});
    assign o_done   = r_busy && (r_step == STEP_WIDTH'(STEP_DONE));

endmodule

@@ rtl/fti_core.sv @@
// fti_core: iteration sequencer holding z, the squares and the escape bookkeeping
// drives one fti_fixmul for all three products of an iteration; depends on fti_pkg
module fti_core
    import fti_pkg::*;
#(
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [Z_WIDTH-1:0] i_pr,
    input  logic signed [Z_WIDTH-1:0] i_pi,
    input  logic signed [Z_WIDTH-1:0] i_cr,
    input  logic signed [Z_WIDTH-1:0] i_ci,
    input  logic [COUNT_WIDTH-1:0]    i_max_iter,
    output logic                      o_idle,
    output logic                      o_res_valid,
    input  logic                      i_res_taken,
    output logic [COUNT_WIDTH-1:0]    o_res_count,
    output logic [MAG_WIDTH-1:0]      o_res_mag
);

    localparam logic [Z_WIDTH-1:0] ESCAPE = Z_WIDTH'(4) << FRAC_BITS;

    t_core_state               r_state, n_state;
    t_prod                     r_prod, n_prod;
    logic signed [Z_WIDTH-1:0] r_zr, n_zr;
    logic signed [Z_WIDTH-1:0] r_zi, n_zi;
    logic signed [Z_WIDTH-1:0] r_cr, n_cr;
    logic signed [Z_WIDTH-1:0] r_ci, n_ci;
    logic signed [Z_WIDTH-1:0] r_r2, n_r2;
    logic signed [Z_WIDTH-1:0] r_i2, n_i2;
    logic signed [Z_WIDTH-1:0] r_cross, n_cross;
    logic [COUNT_WIDTH-1:0]    r_iter, n_iter;
    logic                      r_escaped, n_escaped;
    logic                      r_post, n_post;
    logic [COUNT_WIDTH-1:0]    r_res_count, n_res_count;
    logic [MAG_WIDTH-1:0]      r_res_mag, n_res_mag;

    t_mul_req                  mul_req;
    logic signed [Z_WIDTH-1:0] mul_a;
    logic signed [Z_WIDTH-1:0] mul_b;
    logic                      mul_done;
    logic signed [Z_WIDTH-1:0] mul_result;

    logic signed [Z_WIDTH+1:0] sum_re;
    logic signed [Z_WIDTH+1:0] sum_im;
    logic signed [Z_WIDTH-1:0] new_re;
    logic signed [Z_WIDTH-1:0] new_im;
    logic [Z_WIDTH-1:0]        mag_sq;
    logic [MAG_WIDTH-1:0]      mag_clip;
    logic                      escape_hit;

    // shared multiplier
    assign mul_a = (r_prod == PROD_II) ? r_zi : r_zr;
    assign mul_b = (r_prod == PROD_RR) ? r_zr : r_zi;

    fti_fixmul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_fixmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mul_req),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .o_done   (mul_done),
        .o_result (mul_result)
    );

    // z update and magnitude from the truncated squares
    assign sum_re     = (Z_WIDTH+2)'(r_r2) - (Z_WIDTH+2)'(r_i2) + (Z_WIDTH+2)'(r_cr);
    assign sum_im     = (Z_WIDTH+2)'(r_cross) + (Z_WIDTH+2)'(r_ci);
    assign new_re     = sat_z(sum_re);
    assign new_im     = sat_z(sum_im);
    assign mag_sq     = {1'b0, r_r2[Z_WIDTH-2:0]} + {1'b0, r_i2[Z_WIDTH-2:0]};
    assign escape_hit = (mag_sq >= ESCAPE);
    assign mag_clip   = (|mag_sq[Z_WIDTH-1:MAG_WIDTH]) ? MAG_MAX : mag_sq[MAG_WIDTH-1:0];

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod      <= n_prod;
        r_zr        <= n_zr;
        r_zi        <= n_zi;
        r_cr        <= n_cr;
        r_ci        <= n_ci;
        r_r2        <= n_r2;
        r_i2        <= n_i2;
        r_cross     <= n_cross;
        r_iter      <= n_iter;
        r_escaped   <= n_escaped;
        r_post      <= n_post;
        r_res_count <= n_res_count;
        r_res_mag   <= n_res_mag;
    end

    // next state and sequencing
    always_comb begin
        n_state     = r_state;
        n_prod      = r_prod;
        n_zr        = r_zr;
        n_zi        = r_zi;
        n_cr        = r_cr;
        n_ci        = r_ci;
        n_r2        = r_r2;
        n_i2        = r_i2;
        n_cross     = r_cross;
        n_iter      = r_iter;
        n_escaped   = r_escaped;
        n_post      = r_post;
        n_res_count = r_res_count;
        n_res_mag   = r_res_mag;
        mul_req     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_zr      = i_pr;
                    n_zi      = i_pi;
                    n_cr      = i_cr;
                    n_ci      = i_ci;
                    n_iter    = '0;
                    n_escaped = 1'b0;
                    n_post    = 1'b0;
                    n_prod    = PROD_RR;
                    n_state   = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                mul_req.start      = 1'b1;
                mul_req.half_shift = (r_prod == PROD_RI);
                n_state            = ST_WAIT;
            end
            ST_WAIT: begin
                if (mul_done) begin
                    unique case (r_prod)
                        PROD_RR: begin
                            n_r2    = mul_result;
                            n_prod  = PROD_II;
                            n_state = ST_ISSUE;
                        end
                        PROD_II: begin
                            n_i2    = mul_result;
                            n_prod  = PROD_RI;
                            n_state = ST_ISSUE;
                        end
                        PROD_RI: begin
                            n_cross = mul_result;
                            n_state = ST_UPDATE;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_UPDATE: begin
                n_prod = PROD_RR;
                if (r_escaped) begin
                    // two extra iterations after escape, then report
                    if (r_post) begin
                        n_zr    = new_re;
                        n_zi    = new_im;
                        n_post  = 1'b0;
                        n_state = ST_ISSUE;
                    end else begin
                        n_res_count = r_iter;
                        n_res_mag   = mag_clip;
                        n_state     = ST_DONE;
                    end
                end else if (r_iter != '0 && escape_hit) begin
                    n_escaped = 1'b1;
                    n_post    = 1'b1;
                    n_zr      = new_re;
                    n_zi      = new_im;
                    n_state   = ST_ISSUE;
                end else if (r_iter == i_max_iter) begin
                    // bounded point
                    n_res_count = '0;
                    n_res_mag   = '0;
                    n_state     = ST_DONE;
                end else begin
                    n_zr    = new_re;
                    n_zi    = new_im;
                    n_iter  = r_iter + COUNT_WIDTH'(1);
                    n_state = ST_ISSUE;
                end
            end
            ST_DONE: begin
                if (i_res_taken) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_idle      = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res_count = r_res_count;
    assign o_res_mag   = r_res_mag;

endmodule

@@ rtl/escape_time_fractal_iterator.sv @@
// Escape-time fractal iterator: one complex point in, one (count, |z|^2) result out.
// A point is iterated z = z*z + c with a single shared multiplier that builds each 64x64
// product from four 32x32 partial products; an iteration is three products plus an update.
// The reset limit of max_iterations is 256. One point is in work at a time; its result sits
// in an output register so that the next point can be taken while the result waits. The
// user must see that configuration is written only while the block is idle; the block
// itself does not enforce it. Depends on fti_pkg, fti_core and fti_fixmul.
module escape_time_fractal_iterator
    import fti_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [1:0]                             i_cfg_index,
    input  logic [(COORD_WIDTH > COUNT_WIDTH ? COORD_WIDTH : COUNT_WIDTH)-1:0] i_cfg_data,
    // point request
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [COORD_WIDTH-1:0]          i_point_real,
    input  logic signed [COORD_WIDTH-1:0]          i_point_imag,
    // result output
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [COUNT_WIDTH-1:0]                 o_escape_count,
    output logic [MAG_WIDTH-1:0]                   o_final_magnitude_sq
);

    localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = COUNT_WIDTH'(256);
    localparam logic [COORD_WIDTH-1:0] C_REAL_RESET   =
        COORD_WIDTH'(-c_real_default_mag(FRAC_BITS));
    localparam logic [COORD_WIDTH-1:0] C_IMAG_RESET   =
        COORD_WIDTH'(c_imag_default_mag(FRAC_BITS));

    logic                          r_kind;
    logic [COUNT_WIDTH-1:0]        r_max_iter;
    logic signed [COORD_WIDTH-1:0] r_c_real;
    logic signed [COORD_WIDTH-1:0] r_c_imag;

    logic                          r_out_valid;
    logic [COUNT_WIDTH-1:0]        r_out_count;
    logic [MAG_WIDTH-1:0]          r_out_mag;

    logic                          core_idle;
    logic                          core_res_valid;
    logic [COUNT_WIDTH-1:0]        core_res_count;
    logic [MAG_WIDTH-1:0]          core_res_mag;
    logic                          in_accept;
    logic                          out_load;
    logic signed [Z_WIDTH-1:0]     pr;
    logic signed [Z_WIDTH-1:0]     pi;
    logic signed [Z_WIDTH-1:0]     cr;
    logic signed [Z_WIDTH-1:0]     ci;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind     <= 1'b0;
            r_max_iter <= MAX_ITER_RESET;
            r_c_real   <= C_REAL_RESET;
            r_c_imag   <= C_IMAG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_KIND:     r_kind     <= i_cfg_data[0];
                CFG_MAX_ITER: r_max_iter <= i_cfg_data[COUNT_WIDTH-1:0];
                CFG_C_REAL:   r_c_real   <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_C_IMAG:   r_c_imag   <= i_cfg_data[COORD_WIDTH-1:0];
                default:      r_kind     <= r_kind;
            endcase
        end
    end

    // widen coordinates and pick c by fractal kind
    assign pr = clamp_z(Z_WIDTH'(i_point_real));
    assign pi = clamp_z(Z_WIDTH'(i_point_imag));
    assign cr = r_kind ? clamp_z(Z_WIDTH'(r_c_real)) : pr;
    assign ci = r_kind ? clamp_z(Z_WIDTH'(r_c_imag)) : pi;

    assign in_accept = i_valid && core_idle;
    assign o_stall   = !core_idle;

    fti_core #(
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_accept),
        .i_pr        (pr),
        .i_pi        (pi),
        .i_cr        (cr),
        .i_ci        (ci),
        .i_max_iter  (r_max_iter),
        .o_idle      (core_idle),
        .o_res_valid (core_res_valid),
        .i_res_taken (out_load),
        .o_res_count (core_res_count),
        .o_res_mag   (core_res_mag)
    );

    // output register, loads when empty or being drained
    assign out_load = core_res_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_count <= core_res_count;
            r_out_mag   <= core_res_mag;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_escape_count       = r_out_count;
    assign o_final_magnitude_sq = r_out_mag;

endmodule
